// ===== hdl/smlf_pkg.sv =====
// ----------------------------------------------------------------------------
// smlf_pkg: shared types and constants for the star MAC learning forwarder
// Header and result beat types, table entry layout and fixed codes.
// ----------------------------------------------------------------------------
package smlf_pkg;

	localparam int unsigned SPOKES_DEF      = 4;
	localparam int unsigned TABLE_DEPTH_DEF = 16;
	localparam int unsigned MAC_W           = 48;

	localparam logic [2:0]       HUB_NODE  = 3'd4;
	localparam logic [MAC_W-1:0] BCAST_MAC = {MAC_W{1'b1}};

	// one frame header
	typedef struct packed {
		logic [2:0]       node;
		logic [1:0]       in_spoke;
		logic [MAC_W-1:0] src_mac;
		logic [MAC_W-1:0] dst_mac;
		logic             from_local;
	} req_t;

	// one forwarding decision
	typedef struct packed {
		logic [3:0] hub_port_mask;
		logic       to_hub;
		logic       to_local;
		logic       dest_known;
		logic       learn_dropped;
	} rsp_t;

	// one table entry
	typedef struct packed {
		logic [MAC_W-1:0] mac;
		logic [1:0]       spoke;
	} entry_t;

	// lookup outcome handed from the engine to the decision stage
	typedef struct packed {
		logic       fin;
		req_t       item;
		logic       known;
		logic [1:0] spoke;
		logic       dropped;
	} lookup_t;

endpackage

// ===== hdl/smlf_table.sv =====
// ----------------------------------------------------------------------------
// smlf_table: MAC table storage
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
module smlf_table
	import smlf_pkg::*;
#(
	parameter int unsigned DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [IDX_W-1:0] waddr,
	input  entry_t           wdata,
	input  logic             re,
	input  logic [IDX_W-1:0] raddr,
	output entry_t           rdata
);

	entry_t mem [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== hdl/smlf_engine.sv =====
// ----------------------------------------------------------------------------
// smlf_engine: table scan and learning sequencer
// Scans the filled part of the table once, matching source and destination
// together, then learns the source and reports the lookup.
// ----------------------------------------------------------------------------
module smlf_engine
	import smlf_pkg::*;
#(
	parameter int unsigned SPOKES = SPOKES_DEF,
	parameter int unsigned DEPTH  = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(DEPTH),
	localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  req_t             req,
	output logic             busy,
	output logic             we,
	output logic [IDX_W-1:0] waddr,
	output entry_t           wdata,
	output logic             re,
	output logic [IDX_W-1:0] raddr,
	input  entry_t           rdata,
	output lookup_t          lookup
);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_FIN} state_t;

	state_t           state_q;
	req_t             item_q;
	logic             learn_q;
	logic             same_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] ptr_q;
	logic             pend_s1;
	logic [IDX_W-1:0] pidx_s1;
	logic             src_hit_q;
	logic [IDX_W-1:0] src_idx_q;
	logic             dst_hit_q;
	logic [1:0]       dst_spoke_q;

	logic accept;
	logic is_spoke;
	logic full;
	logic dropped;

	assign accept   = start && (state_q == ST_IDLE);
	assign is_spoke = req.node < 3'(SPOKES);
	assign full     = count_q == CNT_W'(DEPTH);
	assign busy     = state_q != ST_IDLE;

	assign re    = (state_q == ST_SCAN) && (ptr_q < count_q);
	assign raddr = ptr_q[IDX_W-1:0];

	// fill count marks the valid prefix: entries are never freed
	assign dropped = learn_q && !src_hit_q && full;
	assign we      = (state_q == ST_FIN) && learn_q && !dropped;
	assign waddr   = src_hit_q ? src_idx_q : count_q[IDX_W-1:0];
	assign wdata   = '{mac: item_q.src_mac, spoke: item_q.node[1:0]};

	always_comb begin
		lookup         = '0;
		lookup.fin     = state_q == ST_FIN;
		lookup.item    = item_q;
		lookup.dropped = dropped;
		// a destination equal to the freshly learned source sees the new entry
		if (learn_q && same_q && !dropped) begin
			lookup.known = 1'b1;
			lookup.spoke = item_q.node[1:0];
		end else begin
			lookup.known = dst_hit_q;
			lookup.spoke = dst_spoke_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			ptr_q     <= '0;
			pend_s1   <= 1'b0;
			learn_q   <= 1'b0;
			src_hit_q <= 1'b0;
			dst_hit_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q    <= req;
						learn_q   <= is_spoke && req.from_local && (req.src_mac != BCAST_MAC);
						same_q    <= req.src_mac == req.dst_mac;
						ptr_q     <= '0;
						pend_s1   <= 1'b0;
						src_hit_q <= 1'b0;
						dst_hit_q <= 1'b0;
						state_q   <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					pend_s1 <= re;
					pidx_s1 <= raddr;
					if (re) begin
						ptr_q <= ptr_q + CNT_W'(1);
					end
					if (pend_s1) begin
						if (!src_hit_q && rdata.mac == item_q.src_mac) begin
							src_hit_q <= 1'b1;
							src_idx_q <= pidx_s1;
						end
						if (!dst_hit_q && rdata.mac == item_q.dst_mac) begin
							dst_hit_q   <= 1'b1;
							dst_spoke_q <= rdata.spoke;
						end
					end
					if (!re && !pend_s1) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (we && !src_hit_q) begin
						count_q <= count_q + CNT_W'(1);
					end
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/star_mac_learning_forwarder.sv =====
// ----------------------------------------------------------------------------
// star_mac_learning_forwarder: MAC learning bridge for a hub and spoke star
// Learns source MACs into a shared table and decides where each frame goes.
// ----------------------------------------------------------------------------
// A header beat is taken when start is high and busy is low. One result beat
// follows on rsp with done high for exactly one cycle; it must be taken then,
// since the receiver cannot hold it off. The table RAM has one read port and
// the engine walks the filled entries one per cycle, matching source and
// destination in the same pass, waits for the last read to be compared, then
// writes back the learned entry. A new header may be accepted in the cycle
// done is high. Learned entries are never removed, so the table fills from
// entry 0 upward and a fill count stands in for valid bits; no clearing pass
// is needed after reset. When the table is full a new source is not stored
// and learn_dropped is set; known sources are still updated. The write-back
// ends before busy falls, so a following header always reads the updated
// table.
// ----------------------------------------------------------------------------
module star_mac_learning_forwarder
	import smlf_pkg::*;
#(
	parameter int unsigned SPOKES      = SPOKES_DEF,
	parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(TABLE_DEPTH)
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  req_t req,
	output logic busy,
	output logic done,
	output rsp_t rsp
);

	logic             we;
	logic [IDX_W-1:0] waddr;
	entry_t           wdata;
	logic             re;
	logic [IDX_W-1:0] raddr;
	entry_t           rdata;
	lookup_t          lookup;

	logic done_q;
	rsp_t rsp_q;
	rsp_t rsp_d;

	smlf_table #(
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	smlf_engine #(
		.SPOKES(SPOKES),
		.DEPTH (TABLE_DEPTH)
	) u_engine (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.req   (req),
		.busy  (busy),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata),
		.lookup(lookup)
	);

	// forwarding decision from the lookup outcome
	always_comb begin
		logic       is_hub;
		logic       is_spoke;
		logic       flood;
		logic [3:0] all_mask;
		logic [3:0] excl;

		is_hub   = lookup.item.node == HUB_NODE;
		is_spoke = lookup.item.node < 3'(SPOKES);
		flood    = (lookup.item.dst_mac == BCAST_MAC) || !lookup.known;
		all_mask = 4'((5'd1 << SPOKES) - 5'd1);
		// an out-of-range incoming spoke excludes nobody
		excl     = ({1'b0, lookup.item.in_spoke} < 3'(SPOKES))
			? (4'b0001 << lookup.item.in_spoke) : 4'b0000;
		rsp_d    = '0;

		if (is_hub) begin
			rsp_d.dest_known = lookup.known;
			if (flood) begin
				rsp_d.hub_port_mask = all_mask & ~excl;
			end else begin
				rsp_d.hub_port_mask = 4'b0001 << lookup.spoke;
			end
		end else if (is_spoke) begin
			rsp_d.dest_known    = lookup.known;
			rsp_d.learn_dropped = lookup.dropped;
			if (flood) begin
				rsp_d.to_hub   = lookup.item.from_local;
				rsp_d.to_local = !lookup.item.from_local;
			end else if (lookup.item.node == {1'b0, lookup.spoke}) begin
				// owned here: only frames from the hub go out locally
				rsp_d.to_local = !lookup.item.from_local;
			end else begin
				rsp_d.to_hub = lookup.item.from_local;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= lookup.fin;
		end
	end

	always_ff @(posedge clk) begin
		if (lookup.fin) begin
			rsp_q <= rsp_d;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ===== test/star_mac_learning_forwarder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// star_mac_learning_forwarder_tb: self-checking bench for the star forwarder
// Drives frame headers through the start/busy handshake, mirrors the shared
// MAC table to predict each forwarding decision and checks every done beat.
// ----------------------------------------------------------------------------
module star_mac_learning_forwarder_tb;
	import smlf_pkg::*;

	localparam int unsigned NUM_SPOKES  = SPOKES_DEF;
	localparam int unsigned TBL_DEPTH   = TABLE_DEPTH_DEF;
	localparam int          MAC_POOL_SZ = 22;    // a few more than the table holds
	localparam int          RAND_HDRS   = 1100;
	localparam int          IDLE_LIMIT  = 4000;  // cycles with no beat on either side
	localparam int          TAIL_CYCLES = 3 * (TBL_DEPTH + 4);

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic start  = 1'b0;
	req_t req    = '0;
	logic busy;
	logic done;
	rsp_t rsp;

	// headers waiting for the driver, decisions waiting for the monitor
	req_t header_q[$];
	rsp_t decision_q[$];

	// shadow of the forwarder's MAC table
	bit              tbl_valid [TBL_DEPTH];
	bit [MAC_W-1:0]  tbl_mac   [TBL_DEPTH];
	bit [1:0]        tbl_spoke [TBL_DEPTH];

	bit [MAC_W-1:0]  mac_pool  [MAC_POOL_SZ];

	int err_cnt   = 0;
	int idle_cnt  = 0;
	int burst_left = 0;
	int gap_left   = 0;

	star_mac_learning_forwarder #(
		.SPOKES      (NUM_SPOKES),
		.TABLE_DEPTH (TBL_DEPTH)
	) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.req    (req),
		.busy   (busy),
		.done   (done),
		.rsp    (rsp)
	);

	always #10 clk = ~clk;

	// ------------------------------------------------------------------------
	// Table mirror and forwarding predictor
	// ------------------------------------------------------------------------

	// slot of the valid entry holding mac, -1 on a miss
	function automatic int find_mac(bit [MAC_W-1:0] mac);
		for (int i = 0; i < TBL_DEPTH; i++)
			if (tbl_valid[i] && tbl_mac[i] == mac)
				return i;
		return -1;
	endfunction

	// learns the source (if due) and returns the decision for one header
	function automatic rsp_t forward_decision(req_t h);
		rsp_t r;
		int   hit;
		int   slot;
		bit   at_hub;
		bit   at_spoke;
		bit   flood;
		r        = '0;
		at_hub   = (h.node == HUB_NODE);
		at_spoke = (h.node < NUM_SPOKES);
		// unknown node: nothing learned, all-zero decision
		if (!(at_hub || at_spoke))
			return r;

		// learning only from a spoke's local port, never the broadcast address
		if (at_spoke && h.from_local && h.src_mac != BCAST_MAC) begin
			slot = find_mac(h.src_mac);
			if (slot < 0) begin
				for (int j = 0; j < TBL_DEPTH; j++)
					if (!tbl_valid[j]) begin
						slot = j;
						break;
					end
				if (slot >= 0) begin
					tbl_valid[slot] = 1'b1;
					tbl_mac[slot]   = h.src_mac;
				end
			end
			// full table: no eviction, flag the lost source
			if (slot < 0)
				r.learn_dropped = 1'b1;
			else
				tbl_spoke[slot] = h.node[1:0];
		end

		// lookup sees the table after learning
		hit          = find_mac(h.dst_mac);
		r.dest_known = (hit >= 0);
		flood        = (h.dst_mac == BCAST_MAC) || (hit < 0);

		if (at_hub) begin
			// flood skips the incoming spoke; a spoke index past the last excludes none
			if (flood) begin
				r.hub_port_mask = 4'((1 << NUM_SPOKES) - 1);
				if (h.in_spoke < NUM_SPOKES)
					r.hub_port_mask[h.in_spoke] = 1'b0;
			end else begin
				r.hub_port_mask = 4'(1 << tbl_spoke[hit]);
			end
		end else if (flood) begin
			r.to_hub   = h.from_local;
			r.to_local = !h.from_local;
		end else if (tbl_spoke[hit] == h.node[1:0]) begin
			// owned here: only frames arriving from the hub leave locally
			r.to_local = !h.from_local;
		end else begin
			// owned elsewhere: only local frames go up
			r.to_hub = h.from_local;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Driver: bursts of headers with random gaps between them
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start      <= 1'b0;
			req        <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// beat taken on this edge: mirror its effect on the table now
			if (start && !busy)
				decision_q.push_back(forward_decision(req));

			if (!start || !busy) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (header_q.size() != 0) begin
					req   <= header_q.pop_front();
					start <= 1'b1;
					if (burst_left > 0)
						burst_left--;
					else begin
						burst_left = $urandom_range(1, 12);
						// mix of back-to-back, short and long gaps so idle
						// cycles land on every phase of the table walk
						case ($urandom_range(0, 9))
							0, 1, 2, 3: gap_left = 0;
							4, 5, 6, 7: gap_left = $urandom_range(1, 6);
							8:          gap_left = $urandom_range(7, 25);
							default:    gap_left = $urandom_range(26, 45);
						endcase
					end
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: every done beat is checked against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && done) begin
			if (decision_q.size() == 0) begin
				$display("%0t: unexpected result beat %p", $time, rsp);
				err_cnt++;
			end else begin
				want = decision_q.pop_front();
				if (rsp.hub_port_mask !== want.hub_port_mask) begin
					$display("%0t: hub_port_mask expected %h actual %h",
						$time, want.hub_port_mask, rsp.hub_port_mask);
					err_cnt++;
				end
				if (rsp.to_hub !== want.to_hub) begin
					$display("%0t: to_hub expected %b actual %b",
						$time, want.to_hub, rsp.to_hub);
					err_cnt++;
				end
				if (rsp.to_local !== want.to_local) begin
					$display("%0t: to_local expected %b actual %b",
						$time, want.to_local, rsp.to_local);
					err_cnt++;
				end
				if (rsp.dest_known !== want.dest_known) begin
					$display("%0t: dest_known expected %b actual %b",
						$time, want.dest_known, rsp.dest_known);
					err_cnt++;
				end
				if (rsp.learn_dropped !== want.learn_dropped) begin
					$display("%0t: learn_dropped expected %b actual %b",
						$time, want.learn_dropped, rsp.learn_dropped);
					err_cnt++;
				end
			end
		end
	end

	// watchdog: a hang shows up as a long run of cycles with no beat at all
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				idle_cnt <= 0;
			else if (idle_cnt >= IDLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end else
				idle_cnt <= idle_cnt + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	function automatic bit [MAC_W-1:0] rand_mac();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[MAC_W-1:0];
	endfunction

	task automatic push_hdr(input logic [2:0] node, input logic [1:0] in_spoke,
		input logic [MAC_W-1:0] src, input logic [MAC_W-1:0] dst, input logic local_port);
		req_t h;
		h.node       = node;
		h.in_spoke   = in_spoke;
		h.src_mac    = src;
		h.dst_mac    = dst;
		h.from_local = local_port;
		header_q.push_back(h);
	endtask

	// sender holds off until every decision has come back
	task automatic drain();
		while (header_q.size() != 0 || start || decision_q.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		logic [2:0]       node;
		logic [MAC_W-1:0] src;
		logic [MAC_W-1:0] dst;
		logic             lcl;
		bit [MAC_W-1:0]   mac_a;
		bit [MAC_W-1:0]   mac_b;
		bit [MAC_W-1:0]   mac_lo;
		bit [MAC_W-1:0]   mac_hi;

		// pool of working addresses; the extremes sit in it so they get learned
		for (int i = 0; i < MAC_POOL_SZ; i++) begin
			mac_pool[i] = rand_mac();
			if (mac_pool[i] == BCAST_MAC)
				mac_pool[i][0] = 1'b0;
		end
		mac_pool[2] = '0;
		mac_pool[3] = BCAST_MAC - 1;
		mac_a  = mac_pool[0];
		mac_b  = mac_pool[1];
		mac_lo = mac_pool[2];
		mac_hi = mac_pool[3];

		// directed part, starting from an empty table
		push_hdr(HUB_NODE, 2'd0, mac_a, BCAST_MAC, 1'b1);  // flood, local flag ignored at hub
		push_hdr(HUB_NODE, 2'd3, BCAST_MAC, mac_b, 1'b0);  // unknown unicast flood
		push_hdr(3'd0, 2'd0, mac_a, mac_b, 1'b0);          // from hub, unknown: local out
		push_hdr(3'd5, 2'd1, mac_a, BCAST_MAC, 1'b1);      // invalid nodes: all zero
		push_hdr(3'd6, 2'd2, mac_a, mac_a, 1'b1);
		push_hdr(3'd7, 2'd3, mac_a, mac_b, 1'b1);
		push_hdr(3'd1, 2'd0, BCAST_MAC, BCAST_MAC, 1'b1);  // broadcast source not learned
		push_hdr(3'd1, 2'd0, mac_a, mac_a, 1'b1);          // learn A, own spoke, local: drop
		push_hdr(3'd2, 2'd0, mac_b, mac_a, 1'b0);          // other spoke, from hub: drop
		push_hdr(3'd2, 2'd0, mac_b, mac_a, 1'b1);          // learn B, other spoke: up
		push_hdr(3'd1, 2'd0, mac_lo, mac_a, 1'b0);         // owned here, from hub: local
		push_hdr(HUB_NODE, 2'd1, mac_lo, mac_a, 1'b0);     // known: single port
		push_hdr(3'd3, 2'd0, mac_a, mac_lo, 1'b1);         // A moves to spoke 3
		push_hdr(HUB_NODE, 2'd2, mac_b, mac_a, 1'b1);
		push_hdr(3'd0, 2'd3, mac_lo, mac_hi, 1'b1);        // all-zero source learned
		push_hdr(3'd3, 2'd1, mac_hi, mac_lo, 1'b1);
		push_hdr(HUB_NODE, 2'd0, mac_lo, mac_hi, 1'b0);
		push_hdr(3'd0, 2'd2, mac_hi, BCAST_MAC, 1'b0);     // broadcast from hub: local

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		drain();

		// random part: mostly pool traffic so the table fills and keeps
		// moving; the pool is larger than the table, so late sources drop
		for (int n = 0; n < RAND_HDRS; n++) begin
			if (n == RAND_HDRS / 2)
				drain();
			if ($urandom_range(0, 99) < 85) begin
				node = 3'($urandom_range(0, 4));
				src  = mac_pool[$urandom_range(0, MAC_POOL_SZ - 1)];
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5: dst = mac_pool[$urandom_range(0, MAC_POOL_SZ - 1)];
					6, 7:             dst = BCAST_MAC;
					8:                dst = rand_mac();
					default:          dst = src;
				endcase
				if ($urandom_range(0, 19) == 0)
					src = BCAST_MAC;
				lcl = 1'($urandom_range(0, 1));
			end else begin
				// noise: any node, raw addresses; rarely learned so the pool keeps the table
				node = 3'($urandom_range(0, 7));
				src  = rand_mac();
				dst  = rand_mac();
				if (node < NUM_SPOKES)
					lcl = ($urandom_range(0, 9) == 0);
				else
					lcl = 1'($urandom_range(0, 1));
			end
			push_hdr(node, 2'($urandom_range(0, 3)), src, dst, lcl);
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (err_cnt == 0 && decision_q.size() == 0)
			$display("PASS");
		else begin
			if (decision_q.size() != 0)
				$display("%0t: %0d decisions never arrived", $time, decision_q.size());
			$display("FAIL");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/smlf_pkg.sv
hdl/smlf_table.sv
hdl/smlf_engine.sv
hdl/star_mac_learning_forwarder.sv
test/star_mac_learning_forwarder_tb.sv
